@@ hdl/spgv_pkg.sv @@
package spgv_pkg;

	// Vector layout.
	localparam int DIMS       = 3;
	localparam int COMP_WIDTH = 21;
	localparam int COMP_FRAC  = 10;
	localparam int VEC_W      = 63;

	// Scalar fields and registers.
	localparam int SCALAR_W = 31;
	localparam int PRESS_W  = 32;
	localparam int DENS_W   = 31;
	localparam int LC_W     = 32;
	localparam int ETA_W    = 17;
	localparam int FRAC_Q   = 16;

	localparam logic [SCALAR_W-1:0] SCALAR_MAX = '1;
	localparam logic [LC_W-1:0]     LC_RESET   = LC_W'(65536);
	localparam logic [ETA_W-1:0]    ETA_RESET  = ETA_W'(655);

	// Configuration port.
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int REG_IDX_BIT = 2;
	localparam logic [0:0] REG_LINEAR_COEFF = 1'b0;
	localparam logic [0:0] REG_ETA_FLOOR    = 1'b1;

	// Separation magnitude.
	localparam int SQ_W      = 2 * COMP_WIDTH;
	localparam int SQRT_IN_W = SQ_W + 12;
	localparam int ROOT_W    = SQRT_IN_W / 2;
	localparam int DEN_W     = ROOT_W + 1;

	// Pressure gradient and Q.
	localparam int DP_W          = PRESS_W + 1;
	localparam int GRAD_W        = DP_W + FRAC_Q;
	localparam int GRAD_SAT_BIT  = SCALAR_W + FRAC_Q;
	localparam int GRAD_LO_W     = (GRAD_SAT_BIT + 1) / 2;
	localparam int GRAD_HI_W     = GRAD_SAT_BIT - GRAD_LO_W;
	localparam int QPROD_W       = LC_W + GRAD_SAT_BIT;

	// Q over density squared.
	localparam int R2_W = 2 * DENS_W;

	// Dot product and work.
	localparam int DOT_W      = 2 * COMP_WIDTH + 2;
	localparam int DOT_MAG_W  = DOT_W - 1;
	localparam int DOT_LO_W   = COMP_WIDTH + 1;
	localparam int DOT_HI_W   = DOT_MAG_W - DOT_LO_W;
	localparam int WORK_SHIFT = 2 * COMP_FRAC;
	localparam int WPROD_W    = SCALAR_W + DOT_MAG_W;
	localparam int ACC_PROD_W = SCALAR_W + COMP_WIDTH + 1;

	// Latencies of the iterative units.
	localparam int SQRT_LAT = ROOT_W;
	localparam int GRAD_LAT = GRAD_W;
	localparam int QP_LAT   = SCALAR_W + 1;

	function automatic logic signed [COMP_WIDTH-1:0] comp_get(
		input logic [VEC_W-1:0] v,
		input int k
	);
		return $signed(v[k*COMP_WIDTH +: COMP_WIDTH]);
	endfunction

endpackage

@@ hdl/sph_pressure_gradient_viscosity.sv @@
// Pairwise artificial viscosity from the pressure difference of a particle pair.
// Input channel: in_valid/in_ready carry one pair item (velocities, separations,
// pressures, densities, kernel gradient). Output channel: out_valid/out_ready
// carry accel, work_out and visc_press for that pair.
// The pipeline depth is set by the iterative units: 27 stages of square root,
// 49 stages of gradient division and 32 stages of Q over density squared,
// plus the multiply and output stages.
// A new item is accepted every cycle while the output is taken; throughput is
// one item per cycle.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated, and the
// waiting result stays on the output ports.
// The APB port writes linear_coeff at address 0 and eta_floor at address 4.
// Registers should only be written while no item is in flight.
// Reset clears all valid bits and loads linear_coeff = 1.0 and
// eta_floor = 655 (about 0.01).
module sph_pressure_gradient_viscosity import spgv_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [VEC_W-1:0]           vel_i,
	input  logic [VEC_W-1:0]           vel_j,
	input  logic [VEC_W-1:0]           sep_i,
	input  logic [VEC_W-1:0]           sep_j,
	input  logic signed [PRESS_W-1:0]  press_i,
	input  logic signed [PRESS_W-1:0]  press_j,
	input  logic [DENS_W-1:0]          dens_i,
	input  logic [DENS_W-1:0]          dens_j,
	input  logic [VEC_W-1:0]           kernel_grad,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [VEC_W-1:0]           accel,
	output logic [SCALAR_W-1:0]        work_out,
	output logic [SCALAR_W-1:0]        visc_press,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready
);

	localparam int T_SQRT = 2 + SQRT_LAT;
	localparam int T_DEN  = T_SQRT + 1;
	localparam int T_GRAD = T_DEN + GRAD_LAT;
	localparam int T_MA   = T_GRAD + 1;
	localparam int T_MB   = T_MA + 1;
	localparam int T_QP   = T_MB + QP_LAT;
	localparam int T_AVG  = T_QP + 1;
	localparam int T_PP   = T_AVG + 1;
	localparam int LAT    = T_PP + 1;

	localparam int DP_DLY   = T_DEN - 1;
	localparam int DENS_DLY = T_MA - 1;
	localparam int QAVG_DLY = T_PP - T_MB;
	localparam int DOT_DLY  = T_AVG - 2;
	localparam int KG_DLY   = T_AVG - 1;

	localparam logic signed [ACC_PROD_W-1:0] ACC_HI =
		ACC_PROD_W'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_PROD_W-1:0] ACC_LO = -ACC_HI - ACC_PROD_W'(1);

	// Configuration registers.
	logic [LC_W-1:0]  lc_q;
	logic [ETA_W-1:0] eta_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q  <= LC_RESET;
			eta_q <= ETA_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[REG_IDX_BIT])
				REG_LINEAR_COEFF: lc_q  <= pwdata[LC_W-1:0];
				REG_ETA_FLOOR:    eta_q <= pwdata[ETA_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_IDX_BIT])
			REG_LINEAR_COEFF: prdata = APB_DW'(lc_q);
			REG_ETA_FLOOR:    prdata = APB_DW'(eta_q);
		endcase
	end

	// Pipeline control: everything moves unless a result is waiting.
	logic vld_q [0:LAT-1];
	logic en;

	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < LAT; m++) vld_q[m] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int m = 1; m < LAT; m++) vld_q[m] <= vld_q[m-1];
		end
	end

	// Stage 1: squares of separation components, velocity products, |dP|.
	logic [SQ_W-1:0]         sq_s1   [2][DIMS];
	logic signed [DOT_W-1:0] prod_s1 [DIMS];
	logic [DP_W-1:0]         dp_s1;
	logic [DENS_W-1:0]       dens_s1 [2];
	logic [VEC_W-1:0]        kg_s1;

	logic [SQ_W-1:0]          sq_c   [2][DIMS];
	logic signed [DOT_W-1:0]  prod_c [DIMS];
	logic signed [DP_W-1:0]   pdiff;
	logic [DP_W-1:0]          dp_c;

	always_comb begin
		logic signed [COMP_WIDTH-1:0] c;
		logic signed [COMP_WIDTH:0]   cx;
		logic signed [COMP_WIDTH:0]   cn;
		logic [COMP_WIDTH-1:0]        a;
		logic signed [COMP_WIDTH:0]   dv;
		logic signed [COMP_WIDTH-1:0] g;
		logic signed [COMP_WIDTH-1:0] vi_c;
		logic signed [COMP_WIDTH-1:0] vj_c;
		for (int k = 0; k < DIMS; k++) begin
			for (int s = 0; s < 2; s++) begin
				c  = comp_get(s == 0 ? sep_i : sep_j, k);
				cx = {c[COMP_WIDTH-1], c};
				cn = -cx;
				a  = c[COMP_WIDTH-1] ? cn[COMP_WIDTH-1:0] : c;
				sq_c[s][k] = SQ_W'(a) * SQ_W'(a);
			end
			vi_c = comp_get(vel_i, k);
			vj_c = comp_get(vel_j, k);
			dv = {vi_c[COMP_WIDTH-1], vi_c} - {vj_c[COMP_WIDTH-1], vj_c};
			g  = comp_get(kernel_grad, k);
			prod_c[k] = DOT_W'(dv) * DOT_W'(g);
		end
		pdiff = {press_i[PRESS_W-1], press_i} - {press_j[PRESS_W-1], press_j};
		dp_c  = pdiff[DP_W-1] ? DP_W'(-pdiff) : DP_W'(pdiff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1      <= sq_c;
			prod_s1    <= prod_c;
			dp_s1      <= dp_c;
			dens_s1[0] <= (dens_i == '0) ? DENS_W'(1) : dens_i;
			dens_s1[1] <= (dens_j == '0) ? DENS_W'(1) : dens_j;
			kg_s1      <= kernel_grad;
		end
	end

	// Stage 2: sums.
	logic [SQRT_IN_W-1:0]    rad_s2 [2];
	logic signed [DOT_W-1:0] dot_s2;

	always_ff @(posedge clk) begin
		logic [SQ_W-1:0]         ssum;
		logic signed [DOT_W-1:0] dsum;
		if (en) begin
			for (int s = 0; s < 2; s++) begin
				ssum = '0;
				for (int k = 0; k < DIMS; k++) ssum = ssum + sq_s1[s][k];
				rad_s2[s] <= SQRT_IN_W'(ssum) << 12;
			end
			dsum = '0;
			for (int k = 0; k < DIMS; k++) dsum = dsum + prod_s1[k];
			dot_s2 <= dsum;
		end
	end

	// Side-band delay lines.
	logic [DP_W-1:0]         dp_d   [0:DP_DLY-1];
	logic [DENS_W-1:0]       dens_d [2][0:DENS_DLY-1];
	logic signed [DOT_W-1:0] dot_d  [0:DOT_DLY-1];
	logic [VEC_W-1:0]        kg_d   [0:KG_DLY-1];
	logic [SCALAR_W-1:0]     qavg_d [0:QAVG_DLY-1];
	logic [SCALAR_W:0]       qsum;

	always_ff @(posedge clk) begin
		if (en) begin
			dp_d[0] <= dp_s1;
			for (int m = 1; m < DP_DLY; m++) dp_d[m] <= dp_d[m-1];
			for (int s = 0; s < 2; s++) begin
				dens_d[s][0] <= dens_s1[s];
				for (int m = 1; m < DENS_DLY; m++) dens_d[s][m] <= dens_d[s][m-1];
			end
			dot_d[0] <= dot_s2;
			for (int m = 1; m < DOT_DLY; m++) dot_d[m] <= dot_d[m-1];
			kg_d[0] <= kg_s1;
			for (int m = 1; m < KG_DLY; m++) kg_d[m] <= kg_d[m-1];
			qavg_d[0] <= qsum[SCALAR_W:1];
			for (int m = 1; m < QAVG_DLY; m++) qavg_d[m] <= qavg_d[m-1];
		end
	end

	// Per side: separation magnitude plus eta floor, gradient division, Q, Q over density squared.
	logic [ROOT_W-1:0]   root   [2];
	logic [DEN_W-1:0]    den_sden [2];
	logic [GRAD_W-1:0]   grad   [2];
	logic                big_sma [2];
	logic [LC_W+GRAD_LO_W-1:0] pl_sma [2];
	logic [LC_W+GRAD_HI_W-1:0] ph_sma [2];
	logic [SCALAR_W-1:0] q_smb  [2];
	logic [R2_W-1:0]     r2_smb [2];
	logic [SCALAR_W-1:0] qp     [2];

	for (genvar s = 0; s < 2; s++) begin : g_side
		logic [DEN_W-1:0]   den_c;
		logic [QPROD_W-1:0] qprod;

		spgv_isqrt u_isqrt (
			.clk      (clk),
			.en       (en),
			.radicand (rad_s2[s]),
			.root     (root[s])
		);

		assign den_c = DEN_W'(root[s]) + DEN_W'(eta_q);

		always_ff @(posedge clk) begin
			if (en) den_sden[s] <= (den_c == '0) ? DEN_W'(1) : den_c;
		end

		spgv_grad_div u_grad_div (
			.clk      (clk),
			.en       (en),
			.dividend ({dp_d[DP_DLY-1], FRAC_Q'(0)}),
			.divisor  (den_sden[s]),
			.quotient (grad[s])
		);

		// Q = linear_coeff * gradP / 2^16 in two partial products.
		always_ff @(posedge clk) begin
			if (en) begin
				big_sma[s] <= (|grad[s][GRAD_W-1:GRAD_SAT_BIT]) && (lc_q != '0);
				pl_sma[s]  <= (LC_W+GRAD_LO_W)'(lc_q) *
					(LC_W+GRAD_LO_W)'(grad[s][GRAD_LO_W-1:0]);
				ph_sma[s]  <= (LC_W+GRAD_HI_W)'(lc_q) *
					(LC_W+GRAD_HI_W)'(grad[s][GRAD_SAT_BIT-1:GRAD_LO_W]);
			end
		end

		assign qprod = QPROD_W'(pl_sma[s]) + (QPROD_W'(ph_sma[s]) << GRAD_LO_W);

		always_ff @(posedge clk) begin
			if (en) begin
				q_smb[s]  <= (big_sma[s] || (|qprod[QPROD_W-1:GRAD_SAT_BIT])) ?
					SCALAR_MAX : qprod[GRAD_SAT_BIT-1:FRAC_Q];
				r2_smb[s] <= R2_W'(dens_d[s][DENS_DLY-1]) * R2_W'(dens_d[s][DENS_DLY-1]);
			end
		end

		spgv_qp_div u_qp_div (
			.clk (clk),
			.en  (en),
			.q   (q_smb[s]),
			.r2  (r2_smb[s]),
			.qp  (qp[s])
		);
	end

	assign qsum = {1'b0, q_smb[0]} + {1'b0, q_smb[1]};

	// Averaged QP.
	logic [SCALAR_W-1:0] qpavg_savg;
	logic [SCALAR_W:0]   qpsum;

	assign qpsum = {1'b0, qp[0]} + {1'b0, qp[1]};

	always_ff @(posedge clk) begin
		if (en) qpavg_savg <= qpsum[SCALAR_W:1];
	end

	// Partial products for work and acceleration.
	logic                         dpos_spp;
	logic [SCALAR_W+DOT_LO_W-1:0] wl_spp;
	logic [SCALAR_W+DOT_HI_W-1:0] wh_spp;
	logic signed [ACC_PROD_W-1:0] ap_spp [DIMS];
	logic signed [DOT_W-1:0]      dot_avg;
	logic [DOT_MAG_W-1:0]         dmag;

	assign dot_avg = dot_d[DOT_DLY-1];
	assign dmag    = dot_avg[DOT_MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dpos_spp <= (dot_avg > 0);
			wl_spp   <= (SCALAR_W+DOT_LO_W)'(qpavg_savg) *
				(SCALAR_W+DOT_LO_W)'(dmag[DOT_LO_W-1:0]);
			wh_spp   <= (SCALAR_W+DOT_HI_W)'(qpavg_savg) *
				(SCALAR_W+DOT_HI_W)'(dmag[DOT_MAG_W-1:DOT_LO_W]);
			for (int k = 0; k < DIMS; k++) begin
				ap_spp[k] <= ACC_PROD_W'($signed({1'b0, qpavg_savg})) *
					ACC_PROD_W'(comp_get(kg_d[KG_DLY-1], k));
			end
		end
	end

	// Output register.
	logic [VEC_W-1:0]    accel_sout;
	logic [SCALAR_W-1:0] work_sout;
	logic [SCALAR_W-1:0] press_sout;
	logic [WPROD_W-1:0]  wfull;
	logic [SCALAR_W-1:0] work_c;
	logic [VEC_W-1:0]    accel_c;

	always_comb begin
		logic signed [ACC_PROD_W-1:0] a;
		wfull = WPROD_W'(wl_spp) + (WPROD_W'(wh_spp) << DOT_LO_W);
		if (!dpos_spp) begin
			work_c = '0;
		end else if (|wfull[WPROD_W-1:SCALAR_W+WORK_SHIFT]) begin
			work_c = SCALAR_MAX;
		end else begin
			work_c = wfull[SCALAR_W+WORK_SHIFT-1:WORK_SHIFT];
		end
		accel_c = '0;
		for (int k = 0; k < DIMS; k++) begin
			a = ap_spp[k] >>> FRAC_Q;
			if (a > ACC_HI) a = ACC_HI;
			if (a < ACC_LO) a = ACC_LO;
			accel_c[k*COMP_WIDTH +: COMP_WIDTH] = a[COMP_WIDTH-1:0];
		end
	end

	// A pair that does no work reports zero everywhere.
	always_ff @(posedge clk) begin
		if (en) begin
			work_sout  <= work_c;
			accel_sout <= (work_c == '0) ? '0 : accel_c;
			press_sout <= (work_c == '0) ? '0 : qavg_d[QAVG_DLY-1];
		end
	end

	assign accel      = accel_sout;
	assign work_out   = work_sout;
	assign visc_press = press_sout;

endmodule

@@ hdl/spgv_isqrt.sv @@
module spgv_isqrt import spgv_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQRT_IN_W-1:0] radicand,
	output logic [ROOT_W-1:0]    root
);

	localparam int RW = SQRT_IN_W + 1;

	logic [SQRT_IN_W-1:0] rem_q [0:SQRT_LAT-1];
	logic [RW-1:0]        res_q [0:SQRT_LAT-1];

	// One result bit per stage, from the top down.
	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (SQRT_IN_W - 2 - 2 * k);
		logic [SQRT_IN_W-1:0] rem_in;
		logic [RW-1:0]        res_in;
		logic [RW-1:0]        trial;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_q[k] <= rem_in - trial[SQRT_IN_W-1:0];
					res_q[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_q[k] <= rem_in;
					res_q[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

@@ hdl/spgv_grad_div.sv @@
module spgv_grad_div import spgv_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [GRAD_W-1:0] dividend,
	input  logic [DEN_W-1:0]  divisor,
	output logic [GRAD_W-1:0] quotient
);

	logic [DEN_W-1:0]  rem_q [0:GRAD_LAT-1];
	logic [GRAD_W-1:0] nq_q  [0:GRAD_LAT-1];
	logic [DEN_W-1:0]  den_q [0:GRAD_LAT-1];

	// Restoring division: the dividend shifts out at the top while the
	// quotient bits shift in at the bottom of the same register.
	for (genvar k = 0; k < GRAD_LAT; k++) begin : g_stage
		logic [DEN_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [GRAD_W-1:0] nq_in;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = dividend;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign nq_in  = nq_q[k-1];
			assign den_in = den_q[k-1];
		end

		assign trial = {rem_in, nq_in[GRAD_W-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_in;
				if (trial >= {1'b0, den_in}) begin
					rem_q[k] <= diff[DEN_W-1:0];
					nq_q[k]  <= {nq_in[GRAD_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= trial[DEN_W-1:0];
					nq_q[k]  <= {nq_in[GRAD_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = nq_q[GRAD_LAT-1];

endmodule

@@ hdl/spgv_qp_div.sv @@
module spgv_qp_div import spgv_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SCALAR_W-1:0] q,
	input  logic [R2_W-1:0]     r2,
	output logic [SCALAR_W-1:0] qp
);

	localparam int NB = QP_LAT - 1;

	logic [R2_W-1:0]     rem_q [0:QP_LAT-1];
	logic [R2_W-1:0]     r2_q  [0:QP_LAT-1];
	logic [SCALAR_W-1:0] quo_q [0:QP_LAT-1];
	logic                sat_q [0:QP_LAT-1];
	logic [R2_W-1:0]     rem_first;

	// The quotient overflows 31 bits exactly when 2*Q reaches dens^2.
	assign rem_first = R2_W'({q, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_first;
			r2_q[0]  <= r2;
			quo_q[0] <= '0;
			sat_q[0] <= rem_first >= r2;
		end
	end

	for (genvar k = 1; k <= NB; k++) begin : g_stage
		logic [R2_W:0] trial;
		logic [R2_W:0] diff;

		assign trial = {rem_q[k-1], 1'b0};
		assign diff  = trial - {1'b0, r2_q[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				r2_q[k]  <= r2_q[k-1];
				sat_q[k] <= sat_q[k-1];
				if (trial >= {1'b0, r2_q[k-1]}) begin
					rem_q[k] <= diff[R2_W-1:0];
					quo_q[k] <= {quo_q[k-1][SCALAR_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= trial[R2_W-1:0];
					quo_q[k] <= {quo_q[k-1][SCALAR_W-2:0], 1'b0};
				end
			end
		end
	end

	assign qp = sat_q[NB] ? SCALAR_MAX : quo_q[NB];

endmodule

@@ hdl/spgv_checker.sv @@
module spgv_sva import spgv_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [VEC_W-1:0]    accel,
	input logic [SCALAR_W-1:0] work_out,
	input logic [SCALAR_W-1:0] visc_press
);

	// No result may appear while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// With the output empty the block must take a new item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with an empty output");

	// A pair without work reports no acceleration and no pressure.
	a_zero_work: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && work_out == '0) |-> (accel == '0 && visc_press == '0))
		else $error("nonzero result for a pair without work");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(accel) && $stable(work_out) && $stable(visc_press)))
		else $error("stalled result changed");

endmodule

bind sph_pressure_gradient_viscosity spgv_sva u_spgv_sva (.*);

@@ dv/spgv_checker.sv @@
module spgv_checker import spgv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [VEC_W-1:0]          vel_i,
	input  logic [VEC_W-1:0]          vel_j,
	input  logic [VEC_W-1:0]          sep_i,
	input  logic [VEC_W-1:0]          sep_j,
	input  logic signed [PRESS_W-1:0] press_i,
	input  logic signed [PRESS_W-1:0] press_j,
	input  logic [DENS_W-1:0]         dens_i,
	input  logic [DENS_W-1:0]         dens_j,
	input  logic [VEC_W-1:0]          kernel_grad,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [VEC_W-1:0]          accel,
	input  logic [SCALAR_W-1:0]       work_out,
	input  logic [SCALAR_W-1:0]       visc_press,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	input  logic                      pready,
	output int                        fail_cnt,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VEC_W-1:0]    accel;
		logic [SCALAR_W-1:0] work;
		logic [SCALAR_W-1:0] press;
	} visc_t;

	localparam longint unsigned SAT = 64'd2147483647;

	logic [LC_W-1:0]  coeff;
	logic [ETA_W-1:0] floor_eta;
	visc_t            visc_q[$];

	function automatic longint comp(input logic [VEC_W-1:0] v, input int k);
		logic signed [COMP_WIDTH-1:0] c;
		c = v[k*COMP_WIDTH +: COMP_WIDTH];
		return longint'(c);
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q for one side of the pair, saturated to the scalar range.
	function automatic longint unsigned side_q(input longint unsigned dp,
			input logic [VEC_W-1:0] sep);
		longint unsigned sq, den, grad, a;
		longint c;
		sq = 0;
		for (int k = 0; k < DIMS; k++) begin
			c = comp(sep, k);
			a = longint'(c < 0 ? -c : c);
			sq += a * a;
		end
		den = root_floor(sq << 12) + longint'(floor_eta);
		if (den == 0)
			den = 1;
		grad = (dp << 16) / den;
		if (grad != 0 && longint'(coeff) > (((64'd1 << 47) - 1) / grad))
			return SAT;
		return (longint'(coeff) * grad) >> 16;
	endfunction

	function automatic longint unsigned side_qp(input longint unsigned q,
			input logic [DENS_W-1:0] dens);
		longint unsigned d, qp;
		d = (dens == 0) ? 1 : longint'(dens);
		qp = (q << 32) / (d * d);
		return (qp > SAT) ? SAT : qp;
	endfunction

	function automatic visc_t viscosity_of();
		visc_t r;
		longint pi, pj, dv, dot, a;
		longint unsigned dp, qi, qj, qavg, qpavg, w;
		pi = longint'(press_i);
		pj = longint'(press_j);
		dp = (pi > pj) ? pi - pj : pj - pi;
		qi = side_q(dp, sep_i);
		qj = side_q(dp, sep_j);
		qavg = (qi + qj) >> 1;
		qpavg = (side_qp(qi, dens_i) + side_qp(qj, dens_j)) >> 1;
		dot = 0;
		for (int k = 0; k < DIMS; k++) begin
			dv = comp(vel_i, k) - comp(vel_j, k);
			dot += dv * comp(kernel_grad, k);
		end
		w = 0;
		if (dot > 0 && qpavg != 0) begin
			if (longint'(dot) > (((64'd1 << 51) - 1) / qpavg))
				w = SAT;
			else
				w = (qpavg * longint'(dot)) >> 20;
		end
		r = '0;
		if (w == 0)
			return r;
		for (int k = 0; k < DIMS; k++) begin
			a = (longint'(qpavg) * comp(kernel_grad, k)) >>> 16;
			if (a < -(64'sd1 <<< (COMP_WIDTH - 1)))
				a = -(64'sd1 <<< (COMP_WIDTH - 1));
			if (a > (64'sd1 <<< (COMP_WIDTH - 1)) - 1)
				a = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
			r.accel[k*COMP_WIDTH +: COMP_WIDTH] = a[COMP_WIDTH-1:0];
		end
		r.work = w[SCALAR_W-1:0];
		r.press = qavg[SCALAR_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		visc_t want;
		if (!arst_n) begin
			coeff     <= LC_RESET;
			floor_eta <= ETA_RESET;
			fail_cnt  <= 0;
			pending   <= 0;
			visc_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[REG_IDX_BIT] == REG_ETA_FLOOR)
					floor_eta <= pwdata[ETA_W-1:0];
				else
					coeff <= pwdata[LC_W-1:0];
			end
			if (in_valid && in_ready)
				visc_q.push_back(viscosity_of());
			if (out_valid && out_ready) begin
				if (visc_q.size() == 0) begin
					$display("%0t: result with none expected: accel %h work %h press %h",
						$time, accel, work_out, visc_press);
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = visc_q.pop_front();
					if (want.accel !== accel || want.work !== work_out ||
							want.press !== visc_press) begin
						if (want.accel !== accel)
							$display("%0t: accel expected %h got %h", $time, want.accel, accel);
						if (want.work !== work_out)
							$display("%0t: work_out expected %h got %h", $time, want.work,
								work_out);
						if (want.press !== visc_press)
							$display("%0t: visc_press expected %h got %h", $time, want.press,
								visc_press);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
			pending <= visc_q.size();
		end
	end

endmodule

@@ dv/tb_sph_pressure_gradient_viscosity.sv @@
module tb_sph_pressure_gradient_viscosity import spgv_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [VEC_W-1:0]          vi, vj, si, sj, g;
		logic signed [PRESS_W-1:0] pi, pj;
		logic [DENS_W-1:0]         di, dj;
	} pair_t;

	logic                      clk, arst_n;
	logic                      in_valid, in_ready, out_valid, out_ready;
	logic [VEC_W-1:0]          vel_i, vel_j, sep_i, sep_j, kernel_grad, accel;
	logic signed [PRESS_W-1:0] press_i, press_j;
	logic [DENS_W-1:0]         dens_i, dens_j;
	logic [SCALAR_W-1:0]       work_out, visc_press;
	logic                      psel, penable, pwrite, pready;
	logic [APB_AW-1:0]         paddr;
	logic [APB_DW-1:0]         pwdata, prdata;
	int                        fail_cnt, pending;
	bit                        steady, hold_req;

	sph_pressure_gradient_viscosity uut (.*);
	spgv_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (400) @(negedge clk);
			end
			out_ready <= steady || ($urandom_range(0, 99) >= 27);
		end
	end

	function automatic logic [VEC_W-1:0] pack3(input int x, input int y, input int z);
		return {z[COMP_WIDTH-1:0], y[COMP_WIDTH-1:0], x[COMP_WIDTH-1:0]};
	endfunction

	function automatic int small_comp();
		return $urandom_range(0, 8191) - 4096;
	endfunction

	function automatic logic [VEC_W-1:0] wide_vec();
		return VEC_W'({$urandom, $urandom});
	endfunction

	function automatic int comp_v(input logic [VEC_W-1:0] v, input int k);
		logic signed [COMP_WIDTH-1:0] c;
		c = v[k*COMP_WIDTH +: COMP_WIDTH];
		return int'(c);
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
	endtask

	task automatic set_regs(input logic [APB_DW-1:0] lc, input logic [APB_DW-1:0] eta);
		apb_write(APB_AW'(REG_LINEAR_COEFF) << REG_IDX_BIT, lc);
		apb_write(APB_AW'(REG_ETA_FLOOR) << REG_IDX_BIT, eta);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pair(input pair_t p);
		while (!steady && $urandom_range(0, 99) < 27) begin
			in_valid <= 0;
			@(negedge clk);
		end
		vel_i <= p.vi; vel_j <= p.vj; sep_i <= p.si; sep_j <= p.sj;
		kernel_grad <= p.g; press_i <= p.pi; press_j <= p.pj;
		dens_i <= p.di; dens_j <= p.dj;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0 || out_valid)
			@(negedge clk);
		repeat (130) @(negedge clk);
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		int gx, gy, gz, s;
		if ($urandom_range(0, 99) < 20) begin
			p.vi = wide_vec(); p.vj = wide_vec(); p.si = wide_vec(); p.sj = wide_vec();
			p.g = wide_vec(); p.pi = $urandom; p.pj = $urandom;
			p.di = DENS_W'($urandom); p.dj = DENS_W'($urandom);
			return p;
		end
		gx = small_comp(); gy = small_comp(); gz = small_comp();
		p.g  = pack3(gx, gy, gz);
		p.vj = pack3(small_comp(), small_comp(), small_comp());
		// Mostly approaching pairs so that work is positive.
		s = ($urandom_range(0, 99) < 65) ? 1 : -1;
		p.vi = pack3(comp_v(p.vj, 0) + s * gx / 2, comp_v(p.vj, 1) + s * gy / 2,
			comp_v(p.vj, 2) + s * gz / 2);
		p.si = pack3(small_comp(), small_comp(), small_comp());
		p.sj = pack3(small_comp(), small_comp(), small_comp());
		p.pi = $urandom_range(0, 1 << 20) - (1 << 19);
		p.pj = $urandom_range(0, 1 << 20) - (1 << 19);
		p.di = DENS_W'(($urandom_range(0, 9) == 0) ? $urandom :
			$urandom_range(16384, 262144));
		p.dj = DENS_W'(($urandom_range(0, 9) == 0) ? $urandom :
			$urandom_range(16384, 262144));
		return p;
	endfunction

	task automatic directed();
		pair_t p;
		int lo, hi;
		lo = -(1 << (COMP_WIDTH - 1));
		hi = (1 << (COMP_WIDTH - 1)) - 1;
		p.vi = '0; p.vj = '0; p.si = '0; p.sj = '0; p.g = '0;
		p.pi = 0; p.pj = 0; p.di = 0; p.dj = 0;
		send_pair(p);
		// Largest pressure difference, zero separations, zero densities.
		p.pi = 32'h7fffffff; p.pj = 32'h80000000;
		p.vi = pack3(hi, hi, hi); p.vj = pack3(lo, lo, lo); p.g = pack3(hi, hi, hi);
		send_pair(p);
		p.pi = 32'h80000000; p.pj = 32'h7fffffff; p.g = pack3(lo, lo, lo);
		p.vi = pack3(lo, lo, lo); p.vj = pack3(hi, hi, hi);
		send_pair(p);
		// Extreme separations and densities.
		p.si = pack3(lo, lo, lo); p.sj = pack3(hi, hi, hi);
		p.di = '1; p.dj = '1;
		send_pair(p);
		p.di = 1; p.dj = 65536;
		send_pair(p);
		p.si = '1; p.sj = '0;
		send_pair(p);
		// Negative dot product gives no work.
		p.vi = pack3(1024, 0, 0); p.vj = '0; p.g = pack3(-1024, 0, 0);
		p.pi = 65536; p.pj = 0; p.di = 65536; p.dj = 65536;
		p.si = pack3(1024, 0, 0); p.sj = pack3(0, 1024, 0);
		send_pair(p);
		// Tiny positive dot that truncates to zero work.
		p.vi = pack3(1, 0, 0); p.g = pack3(1, 0, 0); p.pi = 1; p.pj = 0;
		p.di = '1; p.dj = '1;
		send_pair(p);
		// Ordinary positive work, then one that saturates the accel components.
		p.vi = pack3(2048, -1024, 512); p.g = pack3(1024, -512, 300);
		p.pi = 3 << 16; p.di = 65536;
		send_pair(p);
		p.di = 4; p.dj = 4; p.g = pack3(hi, lo, hi); p.vi = pack3(hi, lo, hi);
		send_pair(p);
		p.pi = 32'h7fffffff; p.pj = 0; p.si = '0; p.sj = '0;
		send_pair(p);
		p.pi = 0; p.pj = 0;
		send_pair(p);
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			send_pair(random_pair());
	endtask

	initial begin
		arst_n = 0; steady = 0; hold_req = 0;
		in_valid = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		vel_i = '0; vel_j = '0; sep_i = '0; sep_j = '0; kernel_grad = '0;
		press_i = '0; press_j = '0; dens_i = '0; dens_j = '0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		directed();
		random_run(300);
		// Sender keeps offering while the receiver holds off.
		steady = 1;
		hold_req = 1;
		random_run(200);
		steady = 0;
		drain();

		set_regs(32'hffffffff, 65536);
		directed();
		random_run(200);
		drain();

		set_regs(0, 1);
		random_run(100);
		drain();

		// A zero floor with zero separations hits the zero denominator case.
		set_regs(32'h00010000, 0);
		directed();
		random_run(100);
		drain();

		set_regs($urandom_range(1 << 14, 1 << 20), $urandom_range(1, 65536));
		random_run(150);
		drain();
		set_regs($urandom, $urandom_range(1, 65536));
		random_run(150);
		drain();
		set_regs(32'h00010000, 655);
		random_run(150);
		drain();

		if (fail_cnt == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/spgv_pkg.sv
hdl/spgv_isqrt.sv
hdl/spgv_grad_div.sv
hdl/spgv_qp_div.sv
hdl/sph_pressure_gradient_viscosity.sv
hdl/spgv_checker.sv
dv/spgv_checker.sv
dv/tb_sph_pressure_gradient_viscosity.sv
